@@ rtl/rwas_pkg.sv @@
package rwas_pkg;

   localparam int unsigned COUNT_WIDTH_DEFAULT  = 16;
   localparam int unsigned COLUMN_WIDTH_DEFAULT = 10;

   localparam int unsigned SUM_WIDTH        = 24;
   localparam int unsigned TICK_WIDTH       = 16;
   localparam int unsigned CHANNEL_WIDTH    = 4;
   localparam int unsigned DBM_WIDTH        = 8;
   localparam int unsigned HEIGHT_WIDTH     = 10;
   localparam int unsigned SCREEN_BITS      = 11;
   localparam int unsigned TOTAL_WIDTH      = 16;
   localparam int unsigned COLUMN_OUT_WIDTH = 10;
   localparam int unsigned CSR_ADDR_WIDTH   = 5;
   localparam int unsigned CSR_DATA_WIDTH   = 32;

   // Item codes of the request beat.
   localparam logic [1:0] ITEM_PACKET = 2'd0;
   localparam logic [1:0] ITEM_TICK   = 2'd1;
   localparam logic [1:0] ITEM_NEXT   = 2'd2;
   localparam logic [1:0] ITEM_PREV   = 2'd3;

   // Result codes of the response beat.
   localparam logic RESULT_COLUMN  = 1'b0;
   localparam logic RESULT_CHANNEL = 1'b1;

   localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_FIRST = 4'd1;
   localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_LAST  = 4'd14;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_WINDOW_TICKS = 3'd0;
   localparam logic [2:0] REG_GRAPH_HEIGHT = 3'd1;
   localparam logic [2:0] REG_SCREEN_WIDTH = 3'd2;
   localparam logic [2:0] REG_FLOOR_DBM    = 3'd3;
   localparam logic [2:0] REG_CEILING_DBM  = 3'd4;

   localparam logic [TICK_WIDTH-1:0]   WINDOW_TICKS_RESET = 16'd100;
   localparam logic [HEIGHT_WIDTH-1:0] GRAPH_HEIGHT_RESET = 10'd200;
   localparam logic [SCREEN_BITS-1:0]  SCREEN_WIDTH_RESET = 11'd320;
   localparam logic [DBM_WIDTH-1:0]    FLOOR_DBM_RESET    = 8'h9C;
   localparam logic [DBM_WIDTH-1:0]    CEILING_DBM_RESET  = 8'hE2;

   typedef struct packed {
      logic [TICK_WIDTH-1:0]   window_ticks;
      logic [HEIGHT_WIDTH-1:0] graph_height;
      logic [SCREEN_BITS-1:0]  screen_width;
      logic [DBM_WIDTH-1:0]    floor_dbm;
      logic [DBM_WIDTH-1:0]    ceiling_dbm;
   } cfg_type;

   typedef struct packed {
      logic take;
      logic take_avg;
      logic start_bar;
      logic take_bar;
      logic send;
   } cmd_type;

   typedef struct packed {
      logic close_window;
      logic is_channel;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ rtl/rwas_if.sv @@
interface rwas_req_if import rwas_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [DBM_WIDTH-1:0] rssi;

   modport source (output valid, req_type, rssi, input ready);
   modport sink (input valid, req_type, rssi, output ready);
endinterface

interface rwas_rsp_if import rwas_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic                        result_kind;
   logic [COLUMN_OUT_WIDTH-1:0] column;
   logic [HEIGHT_WIDTH-1:0]     bar_height;
   logic [DBM_WIDTH-1:0]        avg_dbm;
   logic [TOTAL_WIDTH-1:0]      packet_total;
   logic [CHANNEL_WIDTH-1:0]    channel;

   modport source (output valid, result_kind, column, bar_height, avg_dbm, packet_total,
                   channel, input ready);
   modport sink (input valid, result_kind, column, bar_height, avg_dbm, packet_total,
                 channel, output ready);
endinterface

@@ rtl/rssi_window_average_scope.sv @@
// RSSI window-average scope.
// Request beats carry a packet RSSI, a millisecond tick, or a next/previous
// channel step. Response beats carry either one scope column (window average,
// bar height, packet total, column index) or a channel-changed notice.
// Packet beats and ticks that do not close a window leave the controller idle
// and give no response. A channel step goes straight to the send state. A tick
// that closes a window runs the shared 24-step divider twice, once for the
// average and once for the bar scaling, one quotient bit per cycle, as the
// controller steps through its average, scale, bar and send states. The send
// state waits for the output register to be free before it loads the response.
// One item is in flight at a time; req_chan.ready is high only between items.
// The response sits in an output register, so new packets and ticks keep
// flowing while a finished result waits for rsp_chan.ready; only an item that
// needs to load the response register waits for it to drain.
// Reset clears the sums, counters and column index, sets channel 1 and loads
// the default register values. The user is to write registers over the APB port
// only while no item is in flight; the block itself does not enforce this.
module rssi_window_average_scope import rwas_pkg::*; #(
   parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEFAULT,
   parameter int unsigned COLUMN_WIDTH = COLUMN_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   rwas_req_if.sink                  req_chan,
   rwas_rsp_if.source                rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   rwas_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rwas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rwas_dp #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .COLUMN_WIDTH (COLUMN_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_chan.req_type),
      .rssi             (req_chan.rssi),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_result_kind  (rsp_chan.result_kind),
      .rsp_column       (rsp_chan.column),
      .rsp_bar_height   (rsp_chan.bar_height),
      .rsp_avg_dbm      (rsp_chan.avg_dbm),
      .rsp_packet_total (rsp_chan.packet_total),
      .rsp_channel      (rsp_chan.channel)
   );

endmodule

@@ rtl/rwas_csr.sv @@
module rwas_csr import rwas_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_WINDOW_TICKS: cfg_in.window_ticks = pwdata[TICK_WIDTH-1:0];
            REG_GRAPH_HEIGHT: cfg_in.graph_height = pwdata[HEIGHT_WIDTH-1:0];
            REG_SCREEN_WIDTH: cfg_in.screen_width = pwdata[SCREEN_BITS-1:0];
            REG_FLOOR_DBM:    cfg_in.floor_dbm    = pwdata[DBM_WIDTH-1:0];
            REG_CEILING_DBM:  cfg_in.ceiling_dbm  = pwdata[DBM_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_WINDOW_TICKS: prdata = CSR_DATA_WIDTH'(cfg_ff.window_ticks);
         REG_GRAPH_HEIGHT: prdata = CSR_DATA_WIDTH'(cfg_ff.graph_height);
         REG_SCREEN_WIDTH: prdata = CSR_DATA_WIDTH'(cfg_ff.screen_width);
         REG_FLOOR_DBM:    prdata = CSR_DATA_WIDTH'($signed(cfg_ff.floor_dbm));
         REG_CEILING_DBM:  prdata = CSR_DATA_WIDTH'($signed(cfg_ff.ceiling_dbm));
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks <= WINDOW_TICKS_RESET;
         cfg_ff.graph_height <= GRAPH_HEIGHT_RESET;
         cfg_ff.screen_width <= SCREEN_WIDTH_RESET;
         cfg_ff.floor_dbm    <= FLOOR_DBM_RESET;
         cfg_ff.ceiling_dbm  <= CEILING_DBM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/rwas_div.sv @@
module rwas_div import rwas_pkg::*; #(
   parameter int unsigned DIVIDEND_W = SUM_WIDTH,
   parameter int unsigned DIVISOR_W  = COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Restoring division, one quotient bit per cycle. The dividend shifts out of
   // the top of quo_ff while quotient bits shift in at the bottom.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
         end
         quo_in = {quo_ff[DIVIDEND_W-2:0], ~diff[DIVISOR_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

endmodule

@@ rtl/rwas_dp.sv @@
module rwas_dp import rwas_pkg::*; #(
   parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEFAULT,
   parameter int unsigned COLUMN_WIDTH = COLUMN_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic [1:0]                  req_type,
   input  logic [DBM_WIDTH-1:0]        rssi,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_result_kind,
   output logic [COLUMN_OUT_WIDTH-1:0] rsp_column,
   output logic [HEIGHT_WIDTH-1:0]     rsp_bar_height,
   output logic [DBM_WIDTH-1:0]        rsp_avg_dbm,
   output logic [TOTAL_WIDTH-1:0]      rsp_packet_total,
   output logic [CHANNEL_WIDTH-1:0]    rsp_channel
);

   localparam int unsigned AVG_W = SUM_WIDTH + 1;
   localparam int unsigned CNTX_W = (COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH;
   localparam int unsigned COLX_W =
      (COLUMN_WIDTH > COLUMN_OUT_WIDTH) ? COLUMN_WIDTH : COLUMN_OUT_WIDTH;
   localparam int unsigned CMP_W = (COLUMN_WIDTH > SCREEN_BITS) ? COLUMN_WIDTH : SCREEN_BITS;
   localparam int unsigned PROD_W = DBM_WIDTH + HEIGHT_WIDTH;

   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;
   logic [TICK_WIDTH-1:0]        tick_ff, tick_in;
   logic [COLUMN_WIDTH-1:0]      col_ff, col_in;
   logic [CHANNEL_WIDTH-1:0]     chan_ff, chan_in;
   logic                         kind_ff, kind_in;
   logic signed [AVG_W-1:0]      avg_ff, avg_in;
   logic [HEIGHT_WIDTH-1:0]      bar_ff, bar_in;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_kind_ff, out_kind_in;
   logic [COLUMN_OUT_WIDTH-1:0]  out_col_ff, out_col_in;
   logic [HEIGHT_WIDTH-1:0]      out_bar_ff, out_bar_in;
   logic [DBM_WIDTH-1:0]         out_avg_ff, out_avg_in;
   logic [TOTAL_WIDTH-1:0]       out_total_ff, out_total_in;
   logic [CHANNEL_WIDTH-1:0]     out_chan_ff, out_chan_in;

   logic signed [AVG_W-1:0]      sum_add;
   logic signed [SUM_WIDTH-1:0]  sum_sat;
   logic                         count_full;
   logic [TICK_WIDTH-1:0]        tick_next;
   logic [TICK_WIDTH-1:0]        tick_limit;
   logic                         close_window;
   logic [CHANNEL_WIDTH-1:0]     chan_up, chan_down;
   logic                         sum_neg;
   logic [SUM_WIDTH-1:0]         sum_mag;
   logic                         div_start;
   logic                         div_done;
   logic [SUM_WIDTH-1:0]         div_dividend;
   logic [COUNT_WIDTH-1:0]       div_divisor;
   logic [SUM_WIDTH-1:0]         div_quotient;
   logic signed [AVG_W-1:0]      quo_signed;
   logic signed [AVG_W-1:0]      lo_ext, hi_ext, avg_clamp, off_wide, span_wide;
   logic                         span_empty;
   logic [DBM_WIDTH-1:0]         off, span;
   logic [PROD_W-1:0]            product;
   logic [COLUMN_WIDTH-1:0]      col_inc;
   logic [CMP_W-1:0]             col_cmp;
   logic [CMP_W-1:0]             screen_cmp;
   logic [COLX_W-1:0]            col_wide;
   logic [CNTX_W-1:0]            count_wide;

   // Packet accumulation saturates at the signed sum limits.
   assign sum_add    = AVG_W'(sum_ff) + AVG_W'($signed(rssi));
   assign count_full = &count_ff;
   always_comb begin
      if (sum_add[AVG_W-1] != sum_add[AVG_W-2]) begin
         sum_sat = sum_add[AVG_W-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_sat = sum_add[SUM_WIDTH-1:0];
      end
   end

   assign tick_next    = tick_ff + 1'b1;
   assign tick_limit   = (cfg.window_ticks == '0) ? TICK_WIDTH'(1) : cfg.window_ticks;
   assign close_window = (req_type == ITEM_TICK) && (tick_next >= tick_limit);

   assign chan_up   = (chan_ff >= CHANNEL_LAST) ? CHANNEL_FIRST : chan_ff + 1'b1;
   assign chan_down = (chan_ff <= CHANNEL_FIRST) ? CHANNEL_LAST : chan_ff - 1'b1;

   // The shared divider works on magnitudes; the sign is put back afterwards so
   // that the average truncates toward zero.
   assign sum_neg = sum_ff[SUM_WIDTH-1];
   assign sum_mag = sum_neg ? (~sum_ff + 1'b1) : sum_ff;
   assign quo_signed = sum_neg ? -$signed({1'b0, div_quotient})
                               : $signed({1'b0, div_quotient});

   assign lo_ext     = AVG_W'($signed(cfg.floor_dbm));
   assign hi_ext     = AVG_W'($signed(cfg.ceiling_dbm));
   assign span_empty = (hi_ext <= lo_ext);
   always_comb begin
      if (avg_ff < lo_ext) begin
         avg_clamp = lo_ext;
      end else if (avg_ff > hi_ext) begin
         avg_clamp = hi_ext;
      end else begin
         avg_clamp = avg_ff;
      end
   end
   assign off_wide  = avg_clamp - lo_ext;
   assign span_wide = hi_ext - lo_ext;
   assign off       = off_wide[DBM_WIDTH-1:0];
   assign span      = span_wide[DBM_WIDTH-1:0];
   assign product   = PROD_W'(off) * PROD_W'(cfg.graph_height);

   assign div_start    = (cmd.take && close_window) || cmd.start_bar;
   assign div_dividend = cmd.start_bar ? SUM_WIDTH'(product) : sum_mag;
   assign div_divisor  = cmd.start_bar ? COUNT_WIDTH'(span) : count_ff;

   rwas_div #(
      .DIVIDEND_W (SUM_WIDTH),
      .DIVISOR_W  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign col_inc    = col_ff + 1'b1;
   assign col_cmp    = CMP_W'(col_inc);
   assign screen_cmp = CMP_W'(cfg.screen_width);
   assign col_wide   = COLX_W'(col_ff);
   assign count_wide = CNTX_W'(count_ff);

   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      tick_in      = tick_ff;
      col_in       = col_ff;
      chan_in      = chan_ff;
      kind_in      = kind_ff;
      avg_in       = avg_ff;
      bar_in       = bar_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_col_in   = out_col_ff;
      out_bar_in   = out_bar_ff;
      out_avg_in   = out_avg_ff;
      out_total_in = out_total_ff;
      out_chan_in  = out_chan_ff;

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.take) begin
         case (req_type)
            ITEM_PACKET: begin
               if (!count_full) begin
                  sum_in   = sum_sat;
                  count_in = count_ff + 1'b1;
               end
            end
            ITEM_TICK: begin
               tick_in = close_window ? '0 : tick_next;
               kind_in = RESULT_COLUMN;
            end
            ITEM_NEXT: begin
               chan_in = chan_up;
               kind_in = RESULT_CHANNEL;
            end
            ITEM_PREV: begin
               chan_in = chan_down;
               kind_in = RESULT_CHANNEL;
            end
            default: kind_in = kind_ff;
         endcase
      end

      if (cmd.take_avg) begin
         avg_in = (count_ff == '0) ? lo_ext : quo_signed;
      end

      if (cmd.take_bar) begin
         if (span_empty) begin
            bar_in = '0;
         end else if (div_quotient > SUM_WIDTH'(cfg.graph_height)) begin
            bar_in = cfg.graph_height;
         end else begin
            bar_in = div_quotient[HEIGHT_WIDTH-1:0];
         end
      end

      if (cmd.send) begin
         out_valid_in = 1'b1;
         out_kind_in  = kind_ff;
         out_chan_in  = chan_ff;
         if (kind_ff == RESULT_CHANNEL) begin
            out_col_in   = '0;
            out_bar_in   = '0;
            out_avg_in   = '0;
            out_total_in = '0;
         end else begin
            out_col_in   = col_wide[COLUMN_OUT_WIDTH-1:0];
            out_bar_in   = bar_ff;
            out_avg_in   = avg_ff[DBM_WIDTH-1:0];
            out_total_in = count_wide[TOTAL_WIDTH-1:0];
            sum_in       = '0;
            count_in     = '0;
            col_in       = (col_cmp >= screen_cmp) ? '0 : col_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         tick_ff      <= '0;
         col_ff       <= '0;
         chan_ff      <= CHANNEL_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
         col_ff       <= col_in;
         chan_ff      <= chan_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff      <= kind_in;
      avg_ff       <= avg_in;
      bar_ff       <= bar_in;
      out_kind_ff  <= out_kind_in;
      out_col_ff   <= out_col_in;
      out_bar_ff   <= out_bar_in;
      out_avg_ff   <= out_avg_in;
      out_total_ff <= out_total_in;
      out_chan_ff  <= out_chan_in;
   end

   assign status.close_window = close_window;
   assign status.is_channel   = (req_type == ITEM_NEXT) || (req_type == ITEM_PREV);
   assign status.div_done     = div_done;
   assign status.out_free     = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_column       = out_col_ff;
   assign rsp_bar_height   = out_bar_ff;
   assign rsp_avg_dbm      = out_avg_ff;
   assign rsp_packet_total = out_total_ff;
   assign rsp_channel      = out_chan_ff;

endmodule

@@ rtl/rwas_ctrl.sv @@
module rwas_ctrl import rwas_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_AVG   = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_BAR   = 5'b01000,
      ST_SEND  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.close_window) begin
                  state_in = ST_AVG;
               end else if (status.is_channel) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_AVG: begin
            if (status.div_done) begin
               cmd.take_avg = 1'b1;
               state_in     = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.start_bar = 1'b1;
            state_in      = ST_BAR;
         end
         ST_BAR: begin
            if (status.div_done) begin
               cmd.take_bar = 1'b1;
               state_in     = ST_SEND;
            end
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ bench/rssi_window_average_scope_test.sv @@
module rssi_window_average_scope_test;
   import rwas_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 130;

   typedef struct packed {
      logic                        kind;
      logic [COLUMN_OUT_WIDTH-1:0] column;
      logic [HEIGHT_WIDTH-1:0]     bar;
      logic [DBM_WIDTH-1:0]        avg;
      logic [TOTAL_WIDTH-1:0]      total;
      logic [CHANNEL_WIDTH-1:0]    channel;
   } scope_beat_t;

   typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_CHECKED} row_kind_t;

   typedef struct packed {
      row_kind_t                 kind;
      logic [1:0]                item;
      logic [DBM_WIDTH-1:0]      level;
      logic [16:0]               repeats;
      logic [2:0]                index;
      logic [CSR_DATA_WIDTH-1:0] value;
      scope_beat_t               want;
   } plan_row_t;

   localparam scope_beat_t NO_BEAT = '0;

   // Directed part. Checked rows carry the column or channel beat they must produce.
   localparam plan_row_t PLAN [27] = '{
      '{ROW_CHECKED, ITEM_PREV, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_CHANNEL, 10'd0, 10'd0, 8'h00, 16'd0, 4'd14}},
      '{ROW_CHECKED, ITEM_NEXT, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_CHANNEL, 10'd0, 10'd0, 8'h00, 16'd0, 4'd1}},
      '{ROW_CHECKED, ITEM_NEXT, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_CHANNEL, 10'd0, 10'd0, 8'h00, 16'd0, 4'd2}},
      '{ROW_ITEM, ITEM_PACKET, 8'h7F, 17'd1, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_ITEM, ITEM_TICK, 8'h00, 17'd99, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd0, 10'd200, 8'h7F, 16'd1, 4'd2}},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd1, 10'd0, 8'h9C, 16'd0, 4'd2}},
      '{ROW_ITEM, ITEM_PACKET, 8'h7F, 17'd1, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_ITEM, ITEM_PACKET, 8'h80, 17'd1, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd2, 10'd200, 8'h00, 16'd2, 4'd2}},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_SCREEN_WIDTH, 32'd0, NO_BEAT},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd3, 10'd0, 8'h9C, 16'd0, 4'd2}},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd0, 10'd0, 8'h9C, 16'd0, 4'd2}},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_FLOOR_DBM, 32'hFFFF_FF80, NO_BEAT},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_CEILING_DBM, 32'd0, NO_BEAT},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_GRAPH_HEIGHT, 32'd1023, NO_BEAT},
      '{ROW_ITEM, ITEM_PACKET, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd0, 10'd1023, 8'h00, 16'd1, 4'd2}},
      '{ROW_ITEM, ITEM_PACKET, 8'h80, 17'd65536, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd0, 10'd0, 8'h80, 16'hFFFF, 4'd2}},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_CEILING_DBM, 32'hFFFF_FF80, NO_BEAT},
      '{ROW_ITEM, ITEM_PACKET, 8'hFB, 17'd1, REG_WINDOW_TICKS, 32'd0, NO_BEAT},
      '{ROW_CHECKED, ITEM_TICK, 8'h00, 17'd1, REG_WINDOW_TICKS, 32'd0,
        '{RESULT_COLUMN, 10'd0, 10'd0, 8'hFB, 16'd1, 4'd2}},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_CEILING_DBM, 32'hFFFF_FFE2, NO_BEAT},
      '{ROW_WRITE, ITEM_PACKET, 8'h00, 17'd0, REG_SCREEN_WIDTH, 32'd1024, NO_BEAT},
      '{ROW_ITEM, ITEM_TICK, 8'h00, 17'd1030, REG_WINDOW_TICKS, 32'd0, NO_BEAT}
   };

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   rwas_req_if req_chan();
   rwas_rsp_if rsp_chan();

   rssi_window_average_scope dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Register copies and window state of the scope as the bench predicts it.
   logic [TICK_WIDTH-1:0]          win_ticks;
   logic [HEIGHT_WIDTH-1:0]        full_height;
   logic [SCREEN_BITS-1:0]         screen_cols;
   logic signed [DBM_WIDTH-1:0]    floor_level;
   logic signed [DBM_WIDTH-1:0]    ceiling_level;
   logic signed [SUM_WIDTH-1:0]    rssi_total;
   logic [TOTAL_WIDTH-1:0]         packets_seen;
   logic [TICK_WIDTH-1:0]          ticks_seen;
   logic [COLUMN_OUT_WIDTH-1:0]    next_column;
   logic [CHANNEL_WIDTH-1:0]       radio_channel;

   scope_beat_t pending_beats [$];
   int          failures = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // Works out the beat, if any, that one accepted request beat causes.
   function automatic void scope_step(input logic [1:0] item, input logic signed [7:0] level,
                                      output bit emits, output scope_beat_t beat);
      int sum;
      int mean;
      int lo;
      int hi;
      int clamped;
      int height;
      int limit;
      logic [COLUMN_OUT_WIDTH-1:0] advanced;
      emits = 1'b0;
      beat  = '0;
      case (item)
         ITEM_PACKET: begin
            if (packets_seen != '1) begin
               sum = int'(rssi_total) + int'(level);
               if (sum > 8388607) sum = 8388607;
               if (sum < -8388608) sum = -8388608;
               rssi_total   = sum[SUM_WIDTH-1:0];
               packets_seen = packets_seen + 1'b1;
            end
         end
         ITEM_TICK: begin
            limit      = (win_ticks == 0) ? 1 : int'(win_ticks);
            ticks_seen = ticks_seen + 1'b1;
            if (int'(ticks_seen) >= limit) begin
               mean = (packets_seen != 0) ? int'(rssi_total) / int'(packets_seen)
                                          : int'(floor_level);
               lo = int'(floor_level);
               hi = int'(ceiling_level);
               if (hi <= lo) begin
                  height = 0;
               end else begin
                  clamped = (mean < lo) ? lo : (mean > hi) ? hi : mean;
                  height  = (clamped - lo) * int'(full_height) / (hi - lo);
                  if (height > int'(full_height)) height = int'(full_height);
               end
               emits        = 1'b1;
               beat.kind    = RESULT_COLUMN;
               beat.column  = next_column;
               beat.bar     = height[HEIGHT_WIDTH-1:0];
               beat.avg     = mean[DBM_WIDTH-1:0];
               beat.total   = packets_seen;
               beat.channel = radio_channel;
               // The column index wraps at its register width as well as at the screen.
               advanced = next_column + 1'b1;
               if (int'(advanced) >= int'(screen_cols)) advanced = '0;
               next_column  = advanced;
               rssi_total   = '0;
               packets_seen = '0;
               ticks_seen   = '0;
            end
         end
         ITEM_NEXT, ITEM_PREV: begin
            if (item == ITEM_NEXT) begin
               radio_channel = (radio_channel >= CHANNEL_LAST) ? CHANNEL_FIRST
                                                               : radio_channel + 1'b1;
            end else begin
               radio_channel = (radio_channel <= CHANNEL_FIRST) ? CHANNEL_LAST
                                                                : radio_channel - 1'b1;
            end
            emits        = 1'b1;
            beat.kind    = RESULT_CHANNEL;
            beat.channel = radio_channel;
         end
      endcase
   endfunction

   // Offers one request beat, with a random hold-off first, and predicts on acceptance.
   task automatic send_item(input logic [1:0] item, input logic [7:0] level,
                            output bit emits, output scope_beat_t beat);
      while (!calm && $urandom_range(99) < 18) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= item;
      req_chan.rssi     <= level;
      do @(posedge clock); while (!req_chan.ready);
      scope_step(item, level, emits, beat);
   endtask

   // Stops requests, waits for every predicted beat, then lets a window close finish.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [CSR_DATA_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] mask;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // The write lands at this edge; turn straight into a read of the same register.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_WINDOW_TICKS: begin
            win_ticks = value[TICK_WIDTH-1:0];
            mask      = 32'h0000_FFFF;
         end
         REG_GRAPH_HEIGHT: begin
            full_height = value[HEIGHT_WIDTH-1:0];
            mask        = 32'h0000_03FF;
         end
         REG_SCREEN_WIDTH: begin
            screen_cols = value[SCREEN_BITS-1:0];
            mask        = 32'h0000_07FF;
         end
         REG_FLOOR_DBM: begin
            floor_level = value[DBM_WIDTH-1:0];
            mask        = 32'h0000_00FF;
         end
         REG_CEILING_DBM: begin
            ceiling_level = value[DBM_WIDTH-1:0];
            mask          = 32'h0000_00FF;
         end
         default: mask = '0;
      endcase
      if (((prdata ^ value) & mask) != 0) begin
         $error("register %0d mismatch: expected %0h, got %0h", index, value & mask,
                prdata & mask);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_beat();
      scope_beat_t want;
      if (pending_beats.size() == 0) begin
         $error("unexpected result beat: kind %0d column %0d channel %0d",
                rsp_chan.result_kind, rsp_chan.column, rsp_chan.channel);
         failures++;
      end else begin
         want = pending_beats.pop_front();
         compare_field("result_kind", want.kind, rsp_chan.result_kind);
         compare_field("column", want.column, rsp_chan.column);
         compare_field("bar_height", want.bar, rsp_chan.bar_height);
         compare_field("avg_dbm", int'($signed(want.avg)), int'($signed(rsp_chan.avg_dbm)));
         compare_field("packet_total", want.total, rsp_chan.packet_total);
         compare_field("channel", want.channel, rsp_chan.channel);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_beat();
      rsp_chan.ready <= calm || ($urandom_range(99) >= 18);
   end

   initial begin : stimulus
      bit          emits;
      scope_beat_t beat;
      logic [1:0]  item;
      int          pick;
      int          win;
      int          height;
      int          screen;
      int          bottom_dbm;
      int          top_dbm;

      clock             = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = ITEM_PACKET;
      req_chan.rssi     = '0;
      rsp_chan.ready    = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;

      win_ticks     = WINDOW_TICKS_RESET;
      full_height   = GRAPH_HEIGHT_RESET;
      screen_cols   = SCREEN_WIDTH_RESET;
      floor_level   = FLOOR_DBM_RESET;
      ceiling_level = CEILING_DBM_RESET;
      rssi_total    = '0;
      packets_seen  = '0;
      ticks_seen    = '0;
      next_column   = '0;
      radio_channel = CHANNEL_FIRST;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            settle();
            write_reg(PLAN[i].index, PLAN[i].value);
         end else begin
            for (int n = 0; n < int'(PLAN[i].repeats); n++) begin
               send_item(PLAN[i].item, PLAN[i].level, emits, beat);
               if (PLAN[i].kind == ROW_CHECKED) pending_beats.push_back(PLAN[i].want);
               else if (emits) pending_beats.push_back(beat);
            end
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               win = 1; height = 1; screen = 1; bottom_dbm = -128; top_dbm = -127;
            end
            1: begin
               win = 65535; height = 1023; screen = 1024; bottom_dbm = 0; top_dbm = 0;
            end
            2: begin
               win = 0; height = $urandom_range(1, 1023); screen = 0;
               bottom_dbm = -90; top_dbm = -20;
            end
            default: begin
               win    = $urandom_range(1, 6);
               height = $urandom_range(1, 1023);
               screen = ($urandom_range(3) == 0) ? $urandom_range(0, 1024)
                                                 : $urandom_range(1, 8);
               if ($urandom_range(3) == 0) begin
                  bottom_dbm = -int'($urandom_range(0, 128));
                  top_dbm    = -int'($urandom_range(0, 127));
               end else begin
                  bottom_dbm = -int'($urandom_range(40, 128));
                  top_dbm    = -int'($urandom_range(0, 39));
               end
            end
         endcase
         settle();
         // A long stretch in the middle runs with both sides at full speed.
         calm = (p == 4 || p == 5);
         write_reg(REG_WINDOW_TICKS, 32'(win));
         write_reg(REG_GRAPH_HEIGHT, 32'(height));
         write_reg(REG_SCREEN_WIDTH, 32'(screen));
         write_reg(REG_FLOOR_DBM, 32'(bottom_dbm));
         write_reg(REG_CEILING_DBM, 32'(top_dbm));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99);
            item = (pick < 52) ? ITEM_PACKET : (pick < 88) ? ITEM_TICK
                 : (pick < 94) ? ITEM_NEXT : ITEM_PREV;
            send_item(item, 8'($urandom_range(255)), emits, beat);
            if (emits) pending_beats.push_back(beat);
         end
      end

      calm = 1'b0;
      settle();
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
